// ===== hw/rtl/tmcg_pkg.sv =====
package tmcg_pkg;

  localparam int MAX_SECTIONS = 256;

  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int RAD_W      = 16;
  localparam int TRIG_W     = 16;
  localparam int PH_W       = 32;
  localparam int RCP_Q_W    = 33;
  localparam int RCP_STEPS  = 33;
  localparam int RCP_CNT_W  = 6;
  localparam int CW         = 34;
  localparam int TRI_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int X_W        = 18;
  localparam int Z_W        = 17;

  localparam int CORDIC_STEPS = 16;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
  };

  // pipeline stage numbers
  localparam int ST_RED     = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_DIV_HI  = 2;
  localparam int ST_DIV_LO  = 3;
  localparam int ST_PH      = 4;
  localparam int ST_FOLD    = 5;
  localparam int ST_CORDIC  = 6;
  localparam int ST_ROUND   = ST_CORDIC + CORDIC_STEPS;
  localparam int ST_MIX     = ST_ROUND + 1;
  localparam int ST_PROD    = ST_MIX + 1;
  localparam int ST_OUT     = ST_PROD + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [RAD_W-1:0] OUTER_RADIUS_RST = 16'd2560;
  localparam logic [RAD_W-1:0] INNER_RADIUS_RST = 16'd1280;
  localparam logic [CNT_W-1:0] SEGMENTS_RST     = 9'd20;
  localparam logic [CNT_W-1:0] RINGS_RST        = 9'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTER_RADIUS = 8'd0,
    CFG_INNER_RADIUS = 8'd1,
    CFG_SEGMENTS     = 8'd2,
    CFG_RINGS        = 8'd3
  } cfg_reg_t;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    logic [TRI_W-1:0] cur;
    logic [TRI_W-1:0] nring;
    logic [TRI_W-1:0] nseg;
    logic [TRI_W-1:0] diag;
  } tri_idx_t;

  typedef enum logic {
    RCP_IDLE,
    RCP_RUN
  } rcp_state_t;

  typedef struct packed {
    logic             qb;
    logic [CNT_W-1:0] rem;
  } div_step_t;

  // one restoring divide step, remainder stays below the divisor
  function automatic div_step_t div_step(input logic [CNT_W-1:0] rem, input logic b,
                                         input logic [CNT_W-1:0] d);
    logic [CNT_W:0] sh;
    div_step_t      res;
    sh      = {rem, b};
    res.qb  = (sh >= {1'b0, d});
    res.rem = res.qb ? CNT_W'(sh - {1'b0, d}) : CNT_W'(sh);
    return res;
  endfunction

  function automatic logic [CNT_W-1:0] eff_sections(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (int'(v) > MAX_SECTIONS) begin
      res = CNT_W'(MAX_SECTIONS);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tmcg_in_if.sv =====
interface tmcg_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmcg_pkg::IDX_W-1:0]    ring_index;
  logic [tmcg_pkg::IDX_W-1:0]    segment_index;

  modport source (output valid, ring_index, segment_index, input ready);
  modport sink   (input valid, ring_index, segment_index, output ready);
endinterface

// ===== hw/rtl/tmcg_out_if.sv =====
interface tmcg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tmcg_pkg::X_W-1:0]    x_coord;
  logic signed [tmcg_pkg::X_W-1:0]    y_coord;
  logic signed [tmcg_pkg::Z_W-1:0]    z_coord;
  logic [tmcg_pkg::TRI_W-1:0]         tri_a_first;
  logic [tmcg_pkg::TRI_W-1:0]         tri_a_second;
  logic [tmcg_pkg::TRI_W-1:0]         tri_a_third;
  logic [tmcg_pkg::TRI_W-1:0]         tri_b_first;
  logic [tmcg_pkg::TRI_W-1:0]         tri_b_second;
  logic [tmcg_pkg::TRI_W-1:0]         tri_b_third;

  modport source (output valid, x_coord, y_coord, z_coord, tri_a_first, tri_a_second,
                  tri_a_third, tri_b_first, tri_b_second, tri_b_third, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, tri_a_first, tri_a_second,
                  tri_a_third, tri_b_first, tri_b_second, tri_b_third, output ready);
endinterface

// ===== hw/rtl/tmcg_cfg_if.sv =====
interface tmcg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tmcg_pkg::CFG_IDX_W-1:0]    index;
  logic [tmcg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tmcg_recip.sv =====
// 2^32 / d by restoring division, one quotient bit per cycle
module tmcg_recip (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [tmcg_pkg::CNT_W-1:0]       div_i,
  output logic [tmcg_pkg::RCP_Q_W-1:0]     quo_o,
  output logic [tmcg_pkg::CNT_W-1:0]       rem_o,
  output logic                             busy_o
);

  tmcg_pkg::rcp_state_t              state_r, state_nxt;
  logic [tmcg_pkg::RCP_CNT_W-1:0]    cnt_r;
  logic [tmcg_pkg::RCP_Q_W-1:0]      quo_r;
  logic [tmcg_pkg::CNT_W-1:0]        rem_r;
  tmcg_pkg::div_step_t               step;
  logic                              last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmcg_pkg::RCP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    last      = (cnt_r == tmcg_pkg::RCP_CNT_W'(tmcg_pkg::RCP_STEPS - 1));
    // dividend is a single one at bit 32, fed first
    step      = tmcg_pkg::div_step(rem_r, (cnt_r == '0), div_i);
    state_nxt = state_r;
    if (start) begin
      state_nxt = tmcg_pkg::RCP_RUN;
    end else begin
      unique case (state_r)
        tmcg_pkg::RCP_IDLE: state_nxt = tmcg_pkg::RCP_IDLE;
        tmcg_pkg::RCP_RUN:  state_nxt = last ? tmcg_pkg::RCP_IDLE : tmcg_pkg::RCP_RUN;
        default:            state_nxt = tmcg_pkg::RCP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
    end else if (state_r == tmcg_pkg::RCP_RUN) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= step.rem;
      quo_r <= {quo_r[tmcg_pkg::RCP_Q_W-2:0], step.qb};
    end
  end

  assign quo_o  = quo_r;
  assign rem_o  = rem_r;
  assign busy_o = (state_r == tmcg_pkg::RCP_RUN);

endmodule

// ===== hw/rtl/tmcg_angle.sv =====
// index -> reduced index -> turn phase round(k*2^32/n) -> folded CORDIC angle
module tmcg_angle (
  input  logic                              clk,
  input  tmcg_pkg::stage_en_t               adv,
  input  logic [tmcg_pkg::IDX_W-1:0]        idx_i,
  input  logic [tmcg_pkg::CNT_W-1:0]        cnt_i,
  input  logic [tmcg_pkg::RCP_Q_W-1:0]      rcp_quo_i,
  input  logic [tmcg_pkg::CNT_W-1:0]        rcp_rem_i,
  output logic [tmcg_pkg::IDX_W-1:0]        red_o,
  output logic signed [tmcg_pkg::CW-1:0]    z_o,
  output logic                              flip_o
);

  localparam int NUM_W    = 18;
  localparam int QD_W     = 9;
  localparam int HI_STEPS = 5;
  localparam int LO_STEPS = QD_W - HI_STEPS;
  localparam logic signed [tmcg_pkg::CW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [tmcg_pkg::CW-1:0] HALF    = 34'sd2147483648;

  logic [tmcg_pkg::IDX_W-1:0]     red_r, red_nxt;
  logic [tmcg_pkg::CNT_W-1:0]     red_rem;
  tmcg_pkg::div_step_t            red_st;

  logic [tmcg_pkg::CNT_W-1:0]     k;
  logic [tmcg_pkg::PH_W-1:0]      kq1_r, kq1_nxt, kq2_r, kq3_r;
  logic [NUM_W-1:0]               num_r, num_nxt;

  logic [tmcg_pkg::CNT_W-1:0]     hi_rem_r, hi_rem_nxt;
  logic [HI_STEPS-1:0]            qhi_r, qhi_nxt;
  logic [LO_STEPS-1:0]            lo_r;
  tmcg_pkg::div_step_t            hi_st;

  logic [tmcg_pkg::CNT_W-1:0]     lo_rem;
  logic [LO_STEPS-1:0]            qlo;
  logic [QD_W-1:0]                qd_r;
  tmcg_pkg::div_step_t            lo_st;

  logic [tmcg_pkg::PH_W-1:0]      ph_r;
  logic signed [tmcg_pkg::CW-1:0] zs, z_r, z_nxt;
  logic                           flip_r, flip_nxt;

  // index mod count, one restoring step per bit
  always_comb begin
    red_rem = '0;
    red_st  = '0;
    for (int b = tmcg_pkg::IDX_W - 1; b >= 0; b--) begin
      red_st  = tmcg_pkg::div_step(red_rem, idx_i[b], cnt_i);
      red_rem = red_st.rem;
    end
    red_nxt = tmcg_pkg::IDX_W'(red_rem);
  end

  // 2^32 = Q*n + R, so k*2^32 + n/2 = k*Q*n + (k*R + n/2)
  always_comb begin
    k       = {1'b0, red_r} + 1'b1;
    kq1_nxt = tmcg_pkg::PH_W'(k) * tmcg_pkg::PH_W'(rcp_quo_i);
    num_nxt = NUM_W'(k) * NUM_W'(rcp_rem_i) + NUM_W'(cnt_i >> 1);
  end

  // num < 512*n, so the top bits start below the divisor
  always_comb begin
    hi_rem_nxt = num_r[NUM_W-1:QD_W];
    hi_st      = '0;
    qhi_nxt    = '0;
    for (int b = HI_STEPS - 1; b >= 0; b--) begin
      hi_st      = tmcg_pkg::div_step(hi_rem_nxt, num_r[b + LO_STEPS], cnt_i);
      hi_rem_nxt = hi_st.rem;
      qhi_nxt[b] = hi_st.qb;
    end
  end

  always_comb begin
    lo_rem = hi_rem_r;
    lo_st  = '0;
    qlo    = '0;
    for (int b = LO_STEPS - 1; b >= 0; b--) begin
      lo_st  = tmcg_pkg::div_step(lo_rem, lo_r[b], cnt_i);
      lo_rem = lo_st.rem;
      qlo[b] = lo_st.qb;
    end
  end

  // fold to [-90, 90] degrees, negate at the end
  always_comb begin
    zs       = tmcg_pkg::CW'(signed'(ph_r));
    z_nxt    = zs;
    flip_nxt = 1'b0;
    if (zs > QUARTER) begin
      z_nxt    = zs - HALF;
      flip_nxt = 1'b1;
    end else if (zs < -QUARTER) begin
      z_nxt    = zs + HALF;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[tmcg_pkg::ST_RED]) begin
      red_r <= red_nxt;
    end
    if (adv[tmcg_pkg::ST_MUL]) begin
      kq1_r <= kq1_nxt;
      num_r <= num_nxt;
    end
    if (adv[tmcg_pkg::ST_DIV_HI]) begin
      kq2_r    <= kq1_r;
      hi_rem_r <= hi_rem_nxt;
      qhi_r    <= qhi_nxt;
      lo_r     <= num_r[LO_STEPS-1:0];
    end
    if (adv[tmcg_pkg::ST_DIV_LO]) begin
      kq3_r <= kq2_r;
      qd_r  <= {qhi_r, qlo};
    end
    if (adv[tmcg_pkg::ST_PH]) begin
      ph_r <= kq3_r + tmcg_pkg::PH_W'(qd_r);
    end
    if (adv[tmcg_pkg::ST_FOLD]) begin
      z_r    <= z_nxt;
      flip_r <= flip_nxt;
    end
  end

  assign red_o  = red_r;
  assign z_o    = z_r;
  assign flip_o = flip_r;

endmodule

// ===== hw/rtl/tmcg_cordic.sv =====
// rotation CORDIC, one iteration per stage, then round to Q1.15
module tmcg_cordic (
  input  logic                                 clk,
  input  tmcg_pkg::stage_en_t                  adv,
  input  logic signed [tmcg_pkg::CW-1:0]       z_i,
  input  logic                                 flip_i,
  output logic signed [tmcg_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [tmcg_pkg::TRIG_W-1:0]   sin_o
);

  localparam int N = tmcg_pkg::CORDIC_STEPS;
  localparam logic signed [tmcg_pkg::CW-1:0] HALF_LSB = 34'sd16384;
  localparam logic signed [tmcg_pkg::CW-1:0] Q15_MAX  = 34'sd32767;

  logic signed [tmcg_pkg::CW-1:0]     x_r [N];
  logic signed [tmcg_pkg::CW-1:0]     y_r [N];
  logic signed [tmcg_pkg::CW-1:0]     z_r [N-1];
  logic                               f_r [N];
  logic signed [tmcg_pkg::TRIG_W-1:0] cos_r, sin_r;

  function automatic logic signed [tmcg_pkg::TRIG_W-1:0] to_q15(
      input logic signed [tmcg_pkg::CW-1:0] v, input logic flip);
    logic signed [tmcg_pkg::CW-1:0] t;
    t = (v + HALF_LSB) >>> 15;
    if (flip) begin
      t = -t;
    end
    if (t > Q15_MAX) begin
      t = Q15_MAX;
    end else if (t < -Q15_MAX) begin
      t = -Q15_MAX;
    end
    return tmcg_pkg::TRIG_W'(t);
  endfunction

  for (genvar n = 0; n < N; n++) begin : g_it
    logic signed [tmcg_pkg::CW-1:0] xi, yi, zi, x_nxt, y_nxt;
    logic                           fi;

    if (n == 0) begin : g_first
      assign xi = tmcg_pkg::CORDIC_GAIN;
      assign yi = '0;
      assign zi = z_i;
      assign fi = flip_i;
    end else begin : g_next
      assign xi = x_r[n-1];
      assign yi = y_r[n-1];
      assign zi = z_r[n-1];
      assign fi = f_r[n-1];
    end

    always_comb begin
      if (zi >= 0) begin
        x_nxt = xi - (yi >>> n);
        y_nxt = yi + (xi >>> n);
      end else begin
        x_nxt = xi + (yi >>> n);
        y_nxt = yi - (xi >>> n);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[tmcg_pkg::ST_CORDIC + n]) begin
        x_r[n] <= x_nxt;
        y_r[n] <= y_nxt;
        f_r[n] <= fi;
      end
    end

    // residual angle only steers the following iteration
    if (n < N - 1) begin : g_z
      logic signed [tmcg_pkg::CW-1:0] z_nxt;

      always_comb begin
        if (zi >= 0) begin
          z_nxt = zi - tmcg_pkg::ATAN_TURNS[n];
        end else begin
          z_nxt = zi + tmcg_pkg::ATAN_TURNS[n];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[tmcg_pkg::ST_CORDIC + n]) begin
          z_r[n] <= z_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[tmcg_pkg::ST_ROUND]) begin
      cos_r <= to_q15(x_r[N-1], f_r[N-1]);
      sin_r <= to_q15(y_r[N-1], f_r[N-1]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== hw/rtl/tmcg_index.sv =====
// triangle indices of the quad at (i, j), carried down to the output stage
module tmcg_index (
  input  logic                          clk,
  input  tmcg_pkg::stage_en_t           adv,
  input  logic [tmcg_pkg::IDX_W-1:0]    ring_i,
  input  logic [tmcg_pkg::IDX_W-1:0]    seg_i,
  input  logic [tmcg_pkg::CNT_W-1:0]    rings_i,
  input  logic [tmcg_pkg::CNT_W-1:0]    segs_i,
  output tmcg_pkg::tri_idx_t            tri_o
);

  localparam int BASE_W = tmcg_pkg::IDX_W + tmcg_pkg::CNT_W;

  logic [tmcg_pkg::CNT_W-1:0] ring_inc, seg_inc, ring_nxt, seg_nxt;
  logic [BASE_W-1:0]          cur_base_r, nxt_base_r;
  logic [tmcg_pkg::IDX_W-1:0] seg_r;
  logic [tmcg_pkg::CNT_W-1:0] nseg_r;
  tmcg_pkg::tri_idx_t         sum_nxt;
  tmcg_pkg::tri_idx_t         idx_r [tmcg_pkg::ST_DIV_HI:tmcg_pkg::ST_OUT];

  // wrap to ring 0 / segment 0 after the last one
  always_comb begin
    ring_inc = {1'b0, ring_i} + 1'b1;
    seg_inc  = {1'b0, seg_i} + 1'b1;
    ring_nxt = (ring_inc == rings_i) ? '0 : ring_inc;
    seg_nxt  = (seg_inc == segs_i) ? '0 : seg_inc;
  end

  always_comb begin
    sum_nxt.cur   = tmcg_pkg::TRI_W'(cur_base_r + BASE_W'(seg_r));
    sum_nxt.nring = tmcg_pkg::TRI_W'(nxt_base_r + BASE_W'(seg_r));
    sum_nxt.nseg  = tmcg_pkg::TRI_W'(cur_base_r + BASE_W'(nseg_r));
    sum_nxt.diag  = tmcg_pkg::TRI_W'(nxt_base_r + BASE_W'(nseg_r));
  end

  always_ff @(posedge clk) begin
    if (adv[tmcg_pkg::ST_MUL]) begin
      cur_base_r <= BASE_W'(ring_i) * BASE_W'(segs_i);
      nxt_base_r <= BASE_W'(ring_nxt) * BASE_W'(segs_i);
      seg_r      <= seg_i;
      nseg_r     <= seg_nxt;
    end
    if (adv[tmcg_pkg::ST_DIV_HI]) begin
      idx_r[tmcg_pkg::ST_DIV_HI] <= sum_nxt;
    end
  end

  for (genvar s = tmcg_pkg::ST_DIV_HI + 1; s <= tmcg_pkg::ST_OUT; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv[s]) begin
        idx_r[s] <= idx_r[s-1];
      end
    end
  end

  assign tri_o = idx_r[tmcg_pkg::ST_OUT];

endmodule

// ===== hw/rtl/torus_mesh_cell_generator.sv =====
// Channel  Dir  Word
// in_if    in   ring_index, segment_index (one torus grid cell)
// out_if   out  x/y/z_coord (1/256 units), six triangle vertex indices
// cfg_if   in   index, data: 0 outer_radius, 1 inner_radius, 2 segments, 3 rings
//
// One cell per cycle while the output is not stalled and the dividers are idle.
// Every stage holds its own valid bit and moves when the stage ahead frees up, so
// bubbles close up and a stalled output loses nothing.
// After reset and after each config write, two 33-step dividers form 2^32/count;
// in_ready is held low during the init pulse after reset and while either divider runs.
module torus_mesh_cell_generator (
  input  logic        clk,
  input  logic        rst_n,
  tmcg_in_if.sink     in_if,
  tmcg_out_if.source  out_if,
  tmcg_cfg_if.sink    cfg_if
);

  localparam int L      = tmcg_pkg::NUM_STAGES;
  localparam int M_W    = 34;
  localparam int ZP_W   = 33;
  localparam int XP_W   = M_W + tmcg_pkg::TRIG_W;
  localparam logic signed [XP_W-1:0] RND30 = 50'sd536870912;
  localparam logic signed [ZP_W-1:0] RND15 = 33'sd16384;

  logic [tmcg_pkg::RAD_W-1:0] outer_r, inner_r;
  logic [tmcg_pkg::CNT_W-1:0] segs_r, rings_r;
  logic [tmcg_pkg::CNT_W-1:0] eff_rings, eff_segs;
  logic                       cfg_acc, init_r, start;

  logic [L-1:0]               vld_r;
  tmcg_pkg::stage_en_t        adv;
  logic                       in_acc;

  logic [tmcg_pkg::RCP_Q_W-1:0] quo_t, quo_p;
  logic [tmcg_pkg::CNT_W-1:0]   rem_t, rem_p;
  logic                         busy_t, busy_p;

  logic [tmcg_pkg::IDX_W-1:0]         red_i, red_j;
  logic signed [tmcg_pkg::CW-1:0]     z_t, z_p;
  logic                               flip_t, flip_p;
  logic signed [tmcg_pkg::TRIG_W-1:0] cos_t, sin_t, cos_p, sin_p;
  tmcg_pkg::tri_idx_t                 tri_idx;

  logic signed [M_W-1:0]              m_r;
  logic signed [ZP_W-1:0]             zp_r;
  logic signed [tmcg_pkg::TRIG_W-1:0] cp_r, sp_r;
  logic signed [XP_W-1:0]             xp_r, yp_r, xs, ys;
  logic signed [tmcg_pkg::Z_W-1:0]    zc_r, z_out_r;
  logic signed [ZP_W-1:0]             zs;
  logic signed [tmcg_pkg::X_W-1:0]    x_out_r, y_out_r;

  // configuration
  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid & cfg_if.ready;
  assign start        = init_r | cfg_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r <= tmcg_pkg::OUTER_RADIUS_RST;
      inner_r <= tmcg_pkg::INNER_RADIUS_RST;
      segs_r  <= tmcg_pkg::SEGMENTS_RST;
      rings_r <= tmcg_pkg::RINGS_RST;
      init_r  <= 1'b1;
    end else begin
      init_r <= 1'b0;
      if (cfg_acc) begin
        unique case (cfg_if.index)
          tmcg_pkg::CFG_OUTER_RADIUS: outer_r <= cfg_if.data;
          tmcg_pkg::CFG_INNER_RADIUS: inner_r <= cfg_if.data;
          tmcg_pkg::CFG_SEGMENTS:     segs_r  <= cfg_if.data[tmcg_pkg::CNT_W-1:0];
          tmcg_pkg::CFG_RINGS:        rings_r <= cfg_if.data[tmcg_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign eff_rings = tmcg_pkg::eff_sections(rings_r);
  assign eff_segs  = tmcg_pkg::eff_sections(segs_r);

  // stage flow control
  always_comb begin
    adv[L-1] = ~vld_r[L-1] | out_if.ready;
    for (int s = L - 2; s >= 0; s--) begin
      adv[s] = ~vld_r[s] | adv[s+1];
    end
  end

  assign in_if.ready = adv[0] & ~init_r & ~busy_t & ~busy_p;
  assign in_acc      = in_if.valid & in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_acc;
      end
      for (int s = 1; s < L; s++) begin
        if (adv[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  tmcg_recip u_recip_t (
    .clk(clk), .rst_n(rst_n), .start(start), .div_i(eff_rings),
    .quo_o(quo_t), .rem_o(rem_t), .busy_o(busy_t)
  );

  tmcg_recip u_recip_p (
    .clk(clk), .rst_n(rst_n), .start(start), .div_i(eff_segs),
    .quo_o(quo_p), .rem_o(rem_p), .busy_o(busy_p)
  );

  tmcg_angle u_angle_t (
    .clk(clk), .adv(adv), .idx_i(in_if.ring_index), .cnt_i(eff_rings),
    .rcp_quo_i(quo_t), .rcp_rem_i(rem_t), .red_o(red_i), .z_o(z_t), .flip_o(flip_t)
  );

  tmcg_angle u_angle_p (
    .clk(clk), .adv(adv), .idx_i(in_if.segment_index), .cnt_i(eff_segs),
    .rcp_quo_i(quo_p), .rcp_rem_i(rem_p), .red_o(red_j), .z_o(z_p), .flip_o(flip_p)
  );

  tmcg_cordic u_cordic_t (
    .clk(clk), .adv(adv), .z_i(z_t), .flip_i(flip_t), .cos_o(cos_t), .sin_o(sin_t)
  );

  tmcg_cordic u_cordic_p (
    .clk(clk), .adv(adv), .z_i(z_p), .flip_i(flip_p), .cos_o(cos_p), .sin_o(sin_p)
  );

  tmcg_index u_index (
    .clk(clk), .adv(adv), .ring_i(red_i), .seg_i(red_j),
    .rings_i(eff_rings), .segs_i(eff_segs), .tri_o(tri_idx)
  );

  // m = R*2^15 + r*cos t, then x = m*cos p, y = m*sin p, z = r*sin t
  always_comb begin
    xs = (xp_r + RND30) >>> 30;
    ys = (yp_r + RND30) >>> 30;
    zs = (zp_r + RND15) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (adv[tmcg_pkg::ST_MIX]) begin
      m_r  <= M_W'(signed'({3'b000, outer_r, 15'd0}))
            + M_W'(signed'({1'b0, inner_r}) * cos_t);
      zp_r <= ZP_W'(signed'({1'b0, inner_r}) * sin_t);
      cp_r <= cos_p;
      sp_r <= sin_p;
    end
    if (adv[tmcg_pkg::ST_PROD]) begin
      xp_r <= XP_W'(m_r) * XP_W'(cp_r);
      yp_r <= XP_W'(m_r) * XP_W'(sp_r);
      zc_r <= tmcg_pkg::Z_W'(zs);
    end
    if (adv[tmcg_pkg::ST_OUT]) begin
      x_out_r <= tmcg_pkg::X_W'(xs);
      y_out_r <= tmcg_pkg::X_W'(ys);
      z_out_r <= zc_r;
    end
  end

  assign out_if.valid        = vld_r[L-1];
  assign out_if.x_coord      = x_out_r;
  assign out_if.y_coord      = y_out_r;
  assign out_if.z_coord      = z_out_r;
  assign out_if.tri_a_first  = tri_idx.cur;
  assign out_if.tri_a_second = tri_idx.nring;
  assign out_if.tri_a_third  = tri_idx.nseg;
  assign out_if.tri_b_first  = tri_idx.nseg;
  assign out_if.tri_b_second = tri_idx.nring;
  assign out_if.tri_b_third  = tri_idx.diag;

endmodule

// ===== hw/rtl/tmcg_checker.sv =====
module tmcg_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         cfg_valid,
  input logic                         cfg_ready,
  input logic [tmcg_pkg::TRI_W-1:0]   tri_a_second,
  input logic [tmcg_pkg::TRI_W-1:0]   tri_a_third,
  input logic [tmcg_pkg::TRI_W-1:0]   tri_b_first,
  input logic [tmcg_pkg::TRI_W-1:0]   tri_b_second
);

  logic [5:0] flight_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r <= '0;
    end else if (in_acc && !out_acc) begin
      flight_r <= flight_r + 1'b1;
    end else if (!in_acc && out_acc) begin
      flight_r <= flight_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> flight_r != '0)
    else $error("out word without a cell in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    flight_r <= 6'(tmcg_pkg::NUM_STAGES))
    else $error("more cells in flight than stages");

  a_cfg_recalc: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during divider recompute");

  a_shared_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (tri_a_third == tri_b_first) && (tri_a_second == tri_b_second))
    else $error("triangles disagree on shared edge");

endmodule

bind torus_mesh_cell_generator tmcg_checker u_tmcg_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .cfg_valid(cfg_if.valid),
  .cfg_ready(cfg_if.ready),
  .tri_a_second(out_if.tri_a_second),
  .tri_a_third(out_if.tri_a_third),
  .tri_b_first(out_if.tri_b_first),
  .tri_b_second(out_if.tri_b_second)
);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_WAIT   = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [tmcg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [tmcg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'd255;

  typedef struct {
    logic signed [tmcg_pkg::X_W-1:0] x;
    logic signed [tmcg_pkg::X_W-1:0] y;
    logic signed [tmcg_pkg::Z_W-1:0] z;
    logic [tmcg_pkg::TRI_W-1:0]      cur;
    logic [tmcg_pkg::TRI_W-1:0]      nring;
    logic [tmcg_pkg::TRI_W-1:0]      nseg;
    logic [tmcg_pkg::TRI_W-1:0]      diag;
  } mesh_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tmcg_in_if  in_if ();
  tmcg_out_if out_if ();
  tmcg_cfg_if cfg_if ();

  torus_mesh_cell_generator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #2 clk = ~clk;

  // shadow of the block's registers
  logic [tmcg_pkg::RAD_W-1:0] major_r;
  logic [tmcg_pkg::RAD_W-1:0] tube_r;
  logic [tmcg_pkg::CNT_W-1:0] seg_cnt;
  logic [tmcg_pkg::CNT_W-1:0] ring_cnt;

  mesh_word_t mesh_q[$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  int in_idle = 0;
  int out_stall = 0;
  logic hold_go = 1'b0;
  logic hold_active = 1'b0;

  function automatic int unsigned sections(input logic [tmcg_pkg::CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > tmcg_pkg::MAX_SECTIONS) return tmcg_pkg::MAX_SECTIONS;
    return v;
  endfunction

  // k/m of a turn -> Q1.15 sine and cosine via folded CORDIC
  function automatic void turn_sincos(input int unsigned k, input int unsigned m,
                                      output longint s, output longint c);
    longint unsigned ph;
    longint z, x, y, dx, dy;
    bit flip;
    ph = ((longint'(k) << 32) + longint'(m / 2)) / longint'(m);
    ph &= 64'hFFFF_FFFF;
    z = (ph >= 64'h8000_0000) ? longint'(ph) - (64'sd1 <<< 32) : longint'(ph);
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    x = longint'(tmcg_pkg::CORDIC_GAIN);
    y = 0;
    for (int n = 0; n < tmcg_pkg::CORDIC_STEPS; n++) begin
      dx = y >>> n;
      dy = x >>> n;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(tmcg_pkg::ATAN_TURNS[n]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(tmcg_pkg::ATAN_TURNS[n]);
      end
    end
    x = (x + (64'sd1 <<< 14)) >>> 15;
    y = (y + (64'sd1 <<< 14)) >>> 15;
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
    s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
  endfunction

  function automatic mesh_word_t mesh_cell(input logic [tmcg_pkg::IDX_W-1:0] ri,
                                           input logic [tmcg_pkg::IDX_W-1:0] si);
    mesh_word_t w;
    int unsigned nr, ns, i, j, ni, nj;
    longint st, ct, sp, cp, m;
    nr = sections(ring_cnt);
    ns = sections(seg_cnt);
    i = ri % nr;
    j = si % ns;
    ni = (i + 1 == nr) ? 0 : i + 1;
    nj = (j + 1 == ns) ? 0 : j + 1;
    turn_sincos(i + 1, nr, st, ct);
    turn_sincos(j + 1, ns, sp, cp);
    m = longint'(major_r) * 32768 + longint'(tube_r) * ct;
    w.x = tmcg_pkg::X_W'((m * cp + (64'sd1 <<< 29)) >>> 30);
    w.y = tmcg_pkg::X_W'((m * sp + (64'sd1 <<< 29)) >>> 30);
    w.z = tmcg_pkg::Z_W'((longint'(tube_r) * st + (64'sd1 <<< 14)) >>> 15);
    w.cur   = tmcg_pkg::TRI_W'(i * ns + j);
    w.nring = tmcg_pkg::TRI_W'(ni * ns + j);
    w.nseg  = tmcg_pkg::TRI_W'(i * ns + nj);
    w.diag  = tmcg_pkg::TRI_W'(ni * ns + nj);
    return w;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always begin
    @(posedge clk);
    if (hold_go) begin
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
      hold_go <= 1'b0;
    end
  end

  // result checker and receiver ready
  always @(posedge clk) begin
    mesh_word_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (mesh_q.size() == 0) begin
        $error("unexpected word: no cell pending");
        err_cnt++;
      end else begin
        e = mesh_q.pop_front();
        if (out_if.x_coord !== e.x) begin
          $error("x_coord exp %0d got %0d", e.x, out_if.x_coord); err_cnt++;
        end
        if (out_if.y_coord !== e.y) begin
          $error("y_coord exp %0d got %0d", e.y, out_if.y_coord); err_cnt++;
        end
        if (out_if.z_coord !== e.z) begin
          $error("z_coord exp %0d got %0d", e.z, out_if.z_coord); err_cnt++;
        end
        if (out_if.tri_a_first !== e.cur) begin
          $error("tri_a_first exp %0d got %0d", e.cur, out_if.tri_a_first); err_cnt++;
        end
        if (out_if.tri_a_second !== e.nring) begin
          $error("tri_a_second exp %0d got %0d", e.nring, out_if.tri_a_second); err_cnt++;
        end
        if (out_if.tri_a_third !== e.nseg) begin
          $error("tri_a_third exp %0d got %0d", e.nseg, out_if.tri_a_third); err_cnt++;
        end
        if (out_if.tri_b_first !== e.nseg) begin
          $error("tri_b_first exp %0d got %0d", e.nseg, out_if.tri_b_first); err_cnt++;
        end
        if (out_if.tri_b_second !== e.nring) begin
          $error("tri_b_second exp %0d got %0d", e.nring, out_if.tri_b_second); err_cnt++;
        end
        if (out_if.tri_b_third !== e.diag) begin
          $error("tri_b_third exp %0d got %0d", e.diag, out_if.tri_b_third); err_cnt++;
        end
      end
    end
    out_if.ready <= rst_n && !hold_active && ($urandom_range(99) >= out_stall);
  end

  task automatic send_cell(input logic [tmcg_pkg::IDX_W-1:0] ri,
                           input logic [tmcg_pkg::IDX_W-1:0] si);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle && gap < 20) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ring_index <= ri;
    in_if.segment_index <= si;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    mesh_q.insert(mesh_q.size(), mesh_cell(ri, si));
  endtask

  task automatic drain_all();
    in_if.valid <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tmcg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tmcg_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    unique case (idx)
      tmcg_pkg::CFG_OUTER_RADIUS: major_r = val;
      tmcg_pkg::CFG_INNER_RADIUS: tube_r = val;
      tmcg_pkg::CFG_SEGMENTS:     seg_cnt = tmcg_pkg::CNT_W'(val);
      tmcg_pkg::CFG_RINGS:        ring_cnt = tmcg_pkg::CNT_W'(val);
      default: ;
    endcase
  endtask

  task automatic set_torus(input logic [15:0] r_big, input logic [15:0] r_tube,
                           input logic [15:0] segs, input logic [15:0] rings);
    drain_all();
    write_reg(tmcg_pkg::CFG_OUTER_RADIUS, r_big);
    write_reg(tmcg_pkg::CFG_INNER_RADIUS, r_tube);
    write_reg(tmcg_pkg::CFG_SEGMENTS, segs);
    write_reg(tmcg_pkg::CFG_RINGS, rings);
  endtask

  task automatic test_directed();
    // reset settings, wrap corners and out-of-range indices
    send_cell(8'd0, 8'd0);
    send_cell(8'd19, 8'd19);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd255);
    send_cell(8'd255, 8'd0);
    send_cell(8'd5, 8'd7);
    // largest radii and counts, index reaches 16 bits
    set_torus(16'hFFFF, 16'hFFFF, 16'd256, 16'd256);
    send_cell(8'd255, 8'd255);
    send_cell(8'd0, 8'd0);
    send_cell(8'd63, 8'd191);
    send_cell(8'd127, 8'd127);
    // zero counts act as one, zero radii
    set_torus(16'd0, 16'd0, 16'd0, 16'd0);
    send_cell(8'd0, 8'd0);
    send_cell(8'd200, 8'd3);
    // counts above the max clamp; tube larger than major radius
    set_torus(16'd256, 16'hFFFF, 16'hFFFF, 16'd511);
    send_cell(8'd255, 8'd128);
    send_cell(8'd1, 8'd254);
    set_torus(16'd1, 16'd40000, 16'd1, 16'd3);
    send_cell(8'd2, 8'd0);
    send_cell(8'd170, 8'd85);
    // unused register indexes must not disturb anything
    drain_all();
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_HI, 16'h0000);
    send_cell(8'd1, 8'd0);
    send_cell(8'd3, 8'd9);
  endtask

  task automatic random_torus();
    logic [15:0] segs, rings;
    segs  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32, 1));
    rings = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32, 1));
    set_torus(16'($urandom), 16'($urandom), segs, rings);
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct, input int n);
    int ns, nr;
    in_idle = idle_pct;
    out_stall = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 70 == 0) random_torus();
      ns = sections(seg_cnt);
      nr = sections(ring_cnt);
      // mostly in-range cells, some arbitrary bytes
      if ($urandom_range(4) == 0)
        send_cell(8'($urandom), 8'($urandom));
      else
        send_cell(8'($urandom_range(nr - 1)), 8'($urandom_range(ns - 1)));
    end
  endtask

  task automatic test_backpressure();
    set_torus(16'd3000, 16'd900, 16'd24, 16'd16);
    in_idle = 0;
    out_stall = 0;
    hold_go <= 1'b1;
    for (int k = 0; k < 80; k++) send_cell(8'($urandom), 8'($urandom));
    drain_all();
    for (int k = 0; k < 20; k++) send_cell(8'($urandom_range(15)), 8'($urandom_range(23)));
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ring_index = '0;
    in_if.segment_index = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    major_r = tmcg_pkg::OUTER_RADIUS_RST;
    tube_r = tmcg_pkg::INNER_RADIUS_RST;
    seg_cnt = tmcg_pkg::SEGMENTS_RST;
    ring_cnt = tmcg_pkg::RINGS_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_mix(0, 0, 350);
    test_random_mix(50, 0, 350);
    test_random_mix(0, 50, 350);
    test_random_mix(22, 22, 350);
    test_backpressure();
    drain_all();

    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
